>>> rtl/m68k_effective_address_unit_top_defines.svh
// Assertion macros shared by the effective address unit RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_TOP_DEFINES_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define M68KEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define M68KEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/m68kea_pkg.sv
// Shared types, codes and helper functions for the effective address unit.
// No dependencies; used by the register file and the top level.
package m68kea_pkg;

  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;

  // Input word layout
  localparam int IN_TDATA_W = 104;
  localparam int IN_TUSER_W = 2;
  // Output word layout
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  // Request kinds
  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  // EA modes
  localparam logic [2:0] MODE_DREG    = 3'd0;
  localparam logic [2:0] MODE_AREG    = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // Register field sub-modes of MODE_EXT
  localparam logic [2:0] EXT_ABS_W    = 3'd0;
  localparam logic [2:0] EXT_ABS_L    = 3'd1;
  localparam logic [2:0] EXT_PC_DISP  = 3'd2;
  localparam logic [2:0] EXT_PC_INDEX = 3'd3;
  localparam logic [2:0] EXT_IMM      = 3'd4;

  // Operand sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam logic [1:0] SZ_NONE = 2'd3;

  // Stack pointer register number (byte steps by two)
  localparam logic [2:0] SP_IDX = 3'd7;

  typedef enum logic [2:0] {
    ACT_VALUE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_REG     = 3'd3,
    ACT_INVALID = 3'd4
  } action_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size_code;
    logic [15:0] ext_first;
    logic [15:0] ext_second;
    logic [31:0] ext_pc;
    logic [31:0] value;
  } item_t;

  // Register file read request
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [REG_IDX_W-1:0] index_idx;
  } rf_raddr_t;

  // Register file write request
  typedef struct packed {
    logic                 en;
    logic                 is_addr;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

  // Register file read results
  typedef struct packed {
    logic [DATA_W-1:0] dr;
    logic [DATA_W-1:0] ar;
    logic [DATA_W-1:0] dx;
    logic [DATA_W-1:0] ax;
  } rf_rdata_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] step_amount(input logic [2:0] r, input logic [1:0] sz);
    logic [2:0] s;
    case (sz)
      SZ_BYTE: s = (r == SP_IDX) ? 3'd2 : 3'd1;
      SZ_WORD: s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/m68kea_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package dependency.
module m68kea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/m68kea_regs.sv
// Data and address register files: two RAMs, reset valid bits, write forwarding.
// Depends on m68kea_pkg and m68kea_ram.
module m68kea_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  m68kea_pkg::rf_raddr_t  rd,
  input  m68kea_pkg::rf_wr_t     wr,
  output m68kea_pkg::rf_rdata_t  q
);

  logic [m68kea_pkg::NUM_REGS-1:0]  dvalid_r;
  logic [m68kea_pkg::NUM_REGS-1:0]  avalid_r;
  logic [m68kea_pkg::REG_IDX_W-1:0] reg_idx_r;
  logic [m68kea_pkg::REG_IDX_W-1:0] index_idx_r;
  logic                             dval_a_r, dval_b_r, aval_a_r, aval_b_r;
  m68kea_pkg::rf_wr_t               fwd_r;

  logic [m68kea_pkg::DATA_W-1:0] d_rdata_a, d_rdata_b, a_rdata_a, a_rdata_b;
  logic                          d_we, a_we;
  logic                          fwd_d_a, fwd_d_b, fwd_a_a, fwd_a_b;

  assign d_we = wr.en && !wr.is_addr;
  assign a_we = wr.en && wr.is_addr;

  m68kea_ram #(
    .WIDTH (m68kea_pkg::DATA_W),
    .DEPTH (m68kea_pkg::NUM_REGS)
  ) u_dram (
    .clk     (clk),
    .we      (d_we),
    .waddr   (wr.idx),
    .wdata   (wr.data),
    .re      (rd.en),
    .raddr_a (rd.reg_idx),
    .raddr_b (rd.index_idx),
    .rdata_a (d_rdata_a),
    .rdata_b (d_rdata_b)
  );

  m68kea_ram #(
    .WIDTH (m68kea_pkg::DATA_W),
    .DEPTH (m68kea_pkg::NUM_REGS)
  ) u_aram (
    .clk     (clk),
    .we      (a_we),
    .waddr   (wr.idx),
    .wdata   (wr.data),
    .re      (rd.en),
    .raddr_a (rd.reg_idx),
    .raddr_b (rd.index_idx),
    .rdata_a (a_rdata_a),
    .rdata_b (a_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r  <= '0;
      avalid_r  <= '0;
      fwd_r.en  <= 1'b0;
    end else begin
      if (d_we) begin
        dvalid_r[wr.idx] <= 1'b1;
      end
      if (a_we) begin
        avalid_r[wr.idx] <= 1'b1;
      end
      if (rd.en) begin
        reg_idx_r   <= rd.reg_idx;
        index_idx_r <= rd.index_idx;
        dval_a_r    <= dvalid_r[rd.reg_idx];
        dval_b_r    <= dvalid_r[rd.index_idx];
        aval_a_r    <= avalid_r[rd.reg_idx];
        aval_b_r    <= avalid_r[rd.index_idx];
        // a write on the read edge is not seen by the RAM read; keep it to forward
        fwd_r       <= wr;
      end
    end
  end

  assign fwd_d_a = fwd_r.en && !fwd_r.is_addr && (fwd_r.idx == reg_idx_r);
  assign fwd_d_b = fwd_r.en && !fwd_r.is_addr && (fwd_r.idx == index_idx_r);
  assign fwd_a_a = fwd_r.en && fwd_r.is_addr && (fwd_r.idx == reg_idx_r);
  assign fwd_a_b = fwd_r.en && fwd_r.is_addr && (fwd_r.idx == index_idx_r);

  always_comb begin
    q.dr = fwd_d_a ? fwd_r.data : (dval_a_r ? d_rdata_a : '0);
    q.dx = fwd_d_b ? fwd_r.data : (dval_b_r ? d_rdata_b : '0);
    q.ar = fwd_a_a ? fwd_r.data : (aval_a_r ? a_rdata_a : '0);
    q.ax = fwd_a_b ? fwd_r.data : (aval_b_r ? a_rdata_b : '0);
  end

endmodule

>>> rtl/m68k_effective_address_unit_top.sv
// A taken word sits in the input stage, then in the result register, which parts
// the two sides. Throughput: one word per cycle unless the output stalls; the
// register file read happens on the accept edge and the write-back on the edge
// that loads the result register. While a result waits, input fills only an empty stage.
// Reset (rst_n low, synchronous) empties both stages and marks all sixteen
// registers as zero through per-register valid bits; no clearing pass.
module m68k_effective_address_unit_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[2:0], reg_req[5:3], size_code[7:6], ext_first[23:8], ext_second[39:24],
  // ext_pc[71:40], value[103:72]
  input  logic [m68kea_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [m68kea_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // address[31:0], data[63:32], access_size[65:64], ext_words[67:66], zero[71:68]
  output logic [m68kea_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // action[2:0]
  output logic [m68kea_pkg::OUT_TUSER_W-1:0]  out_tuser
);

`include "m68k_effective_address_unit_top_defines.svh"

  m68kea_pkg::item_t     in_item;
  m68kea_pkg::item_t     a_item_r;
  logic                  a_vld_r;
  logic                  b_move;
  logic                  in_acc;

  m68kea_pkg::rf_raddr_t rf_rd;
  m68kea_pkg::rf_wr_t    rf_wr;
  m68kea_pkg::rf_wr_t    core_wr;
  m68kea_pkg::rf_rdata_t rf_q;

  logic                  out_vld_r;
  m68kea_pkg::action_t   out_action_r;
  logic [31:0]           out_addr_r;
  logic [31:0]           out_data_r;
  logic [1:0]            out_size_r;
  logic [1:0]            out_ext_r;

  m68kea_pkg::action_t   res_action;
  logic [31:0]           res_addr;
  logic [31:0]           res_data;
  logic [1:0]            res_size;
  logic [1:0]            res_ext;

  // decode helpers
  logic [31:0]           mask;
  logic [31:0]           step;
  logic [31:0]           idx_raw;
  logic [31:0]           idx_val;
  logic [31:0]           idx_base;
  logic [31:0]           idx_addr;
  logic [31:0]           disp16;
  logic [31:0]           ext_long;
  logic                  mem_ok;
  logic [31:0]           mem_addr;
  logic [1:0]            mem_ext;
  m68kea_pkg::rf_wr_t    mem_wr;
  logic                  is_acc;

  // unpack the input word
  always_comb begin
    in_item.kind       = in_tuser[1:0];
    in_item.mode       = in_tdata[2:0];
    in_item.reg_req    = in_tdata[5:3];
    in_item.size_code  = in_tdata[7:6];
    in_item.ext_first  = in_tdata[23:8];
    in_item.ext_second = in_tdata[39:24];
    in_item.ext_pc     = in_tdata[71:40];
    in_item.value      = in_tdata[103:72];
  end

  assign b_move    = a_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !a_vld_r || b_move;
  assign in_acc    = in_tvalid && in_tready;

  // read both files at the operand register and the index register
  always_comb begin
    rf_rd.en        = in_acc;
    rf_rd.reg_idx   = in_item.reg_req;
    rf_rd.index_idx = in_item.ext_first[14:12];
  end

  m68kea_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rf_rd),
    .wr    (rf_wr),
    .q     (rf_q)
  );

  // address generation
  always_comb begin
    mask     = m68kea_pkg::size_mask(a_item_r.size_code);
    step     = {29'd0, m68kea_pkg::step_amount(a_item_r.reg_req, a_item_r.size_code)};
    disp16   = m68kea_pkg::sext16(a_item_r.ext_first);
    ext_long = {a_item_r.ext_first, a_item_r.ext_second};
    idx_raw  = a_item_r.ext_first[15] ? rf_q.ax : rf_q.dx;
    idx_val  = a_item_r.ext_first[11] ? idx_raw : m68kea_pkg::sext16(idx_raw[15:0]);
    idx_base = (a_item_r.mode == m68kea_pkg::MODE_INDEX) ? rf_q.ar : a_item_r.ext_pc;
    idx_addr = idx_base + m68kea_pkg::sext8(a_item_r.ext_first[7:0]) + idx_val;

    mem_ok       = 1'b0;
    mem_addr     = '0;
    mem_ext      = 2'd0;
    mem_wr       = '0;
    mem_wr.is_addr = 1'b1;
    mem_wr.idx   = a_item_r.reg_req;
    case (a_item_r.mode)
      m68kea_pkg::MODE_IND: begin
        mem_ok   = 1'b1;
        mem_addr = rf_q.ar;
      end
      m68kea_pkg::MODE_POSTINC: begin
        mem_ok      = 1'b1;
        mem_addr    = rf_q.ar;
        mem_wr.en   = 1'b1;
        mem_wr.data = rf_q.ar + step;
      end
      m68kea_pkg::MODE_PREDEC: begin
        mem_ok      = 1'b1;
        mem_addr    = rf_q.ar - step;
        mem_wr.en   = 1'b1;
        mem_wr.data = rf_q.ar - step;
      end
      m68kea_pkg::MODE_DISP: begin
        mem_ok   = 1'b1;
        mem_addr = rf_q.ar + disp16;
        mem_ext  = 2'd1;
      end
      m68kea_pkg::MODE_INDEX: begin
        mem_ok   = 1'b1;
        mem_addr = idx_addr;
        mem_ext  = 2'd1;
      end
      m68kea_pkg::MODE_EXT: begin
        case (a_item_r.reg_req)
          m68kea_pkg::EXT_ABS_W: begin
            mem_ok   = 1'b1;
            mem_addr = disp16;
            mem_ext  = 2'd1;
          end
          m68kea_pkg::EXT_ABS_L: begin
            mem_ok   = 1'b1;
            mem_addr = ext_long;
            mem_ext  = 2'd2;
          end
          m68kea_pkg::EXT_PC_DISP: begin
            mem_ok   = 1'b1;
            mem_addr = a_item_r.ext_pc + disp16;
            mem_ext  = 2'd1;
          end
          m68kea_pkg::EXT_PC_INDEX: begin
            mem_ok   = 1'b1;
            mem_addr = idx_addr;
            mem_ext  = 2'd1;
          end
          default: begin
            mem_ok = 1'b0;
          end
        endcase
      end
      default: begin
        mem_ok = 1'b0;
      end
    endcase
  end

  // result selection; anything not matched stays invalid with a zero payload
  always_comb begin
    res_action = m68kea_pkg::ACT_INVALID;
    res_addr   = '0;
    res_data   = '0;
    res_size   = 2'd0;
    res_ext    = 2'd0;
    core_wr    = '0;
    core_wr.idx = a_item_r.reg_req;
    is_acc     = (a_item_r.kind == m68kea_pkg::KIND_FETCH ||
                  a_item_r.kind == m68kea_pkg::KIND_STORE) &&
                 (a_item_r.size_code != m68kea_pkg::SZ_NONE);

    if (a_item_r.kind == m68kea_pkg::KIND_LOAD) begin
      if (a_item_r.mode == m68kea_pkg::MODE_DREG ||
          a_item_r.mode == m68kea_pkg::MODE_AREG) begin
        res_action      = m68kea_pkg::ACT_REG;
        res_data        = a_item_r.value;
        res_size        = m68kea_pkg::SZ_LONG;
        core_wr.en      = 1'b1;
        core_wr.is_addr = (a_item_r.mode == m68kea_pkg::MODE_AREG);
        core_wr.data    = a_item_r.value;
      end
    end else if (is_acc) begin
      if (mem_ok) begin
        res_addr = mem_addr;
        res_ext  = mem_ext;
        res_size = a_item_r.size_code;
        core_wr  = mem_wr;
        if (a_item_r.kind == m68kea_pkg::KIND_FETCH) begin
          res_action = m68kea_pkg::ACT_READ;
        end else begin
          res_action = m68kea_pkg::ACT_WRITE;
          res_data   = a_item_r.value & mask;
        end
      end else if (a_item_r.kind == m68kea_pkg::KIND_FETCH) begin
        if (a_item_r.mode == m68kea_pkg::MODE_DREG) begin
          res_action = m68kea_pkg::ACT_VALUE;
          res_data   = rf_q.dr;
          res_size   = a_item_r.size_code;
        end else if (a_item_r.mode == m68kea_pkg::MODE_AREG) begin
          res_action = m68kea_pkg::ACT_VALUE;
          res_data   = rf_q.ar;
          res_size   = a_item_r.size_code;
        end else if (a_item_r.mode == m68kea_pkg::MODE_EXT &&
                     a_item_r.reg_req == m68kea_pkg::EXT_IMM) begin
          res_action = m68kea_pkg::ACT_VALUE;
          res_size   = a_item_r.size_code;
          if (a_item_r.size_code == m68kea_pkg::SZ_LONG) begin
            res_data = ext_long;
            res_ext  = 2'd2;
          end else begin
            res_data = {16'd0, a_item_r.ext_first} & mask;
            res_ext  = 2'd1;
          end
        end
      end else begin
        if (a_item_r.mode == m68kea_pkg::MODE_DREG) begin
          // merge: keep the register bits above the operand size
          res_action      = m68kea_pkg::ACT_REG;
          res_size        = a_item_r.size_code;
          res_data        = (rf_q.dr & ~mask) | (a_item_r.value & mask);
          core_wr.en      = 1'b1;
          core_wr.is_addr = 1'b0;
          core_wr.data    = (rf_q.dr & ~mask) | (a_item_r.value & mask);
        end else if (a_item_r.mode == m68kea_pkg::MODE_AREG) begin
          res_action      = m68kea_pkg::ACT_REG;
          res_size        = a_item_r.size_code;
          res_data        = (a_item_r.size_code == m68kea_pkg::SZ_WORD) ?
                            m68kea_pkg::sext16(a_item_r.value[15:0]) : a_item_r.value;
          core_wr.en      = 1'b1;
          core_wr.is_addr = 1'b1;
          core_wr.data    = res_data;
        end
      end
    end
  end

  // commit the write only when the word moves into the result register
  always_comb begin
    rf_wr    = core_wr;
    rf_wr.en = core_wr.en && b_move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_vld_r  <= 1'b1;
        a_item_r <= in_item;
      end else if (b_move) begin
        a_vld_r <= 1'b0;
      end

      if (b_move) begin
        out_vld_r    <= 1'b1;
        out_action_r <= res_action;
        out_addr_r   <= res_addr;
        out_data_r   <= res_data;
        out_size_r   <= res_size;
        out_ext_r    <= res_ext;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_ext_r, out_size_r, out_data_r, out_addr_r};
  assign out_tuser  = out_action_r;

  `M68KEA_ASSERT_IMP(a_invalid_zero, out_vld_r && (out_action_r == m68kea_pkg::ACT_INVALID), out_tdata == '0, "invalid result carries a payload")
  `M68KEA_ASSERT_IMP(a_write_on_move, rf_wr.en, b_move, "register write without result transfer")
  `M68KEA_ASSERT_NXT(a_hold_stage, a_vld_r && !b_move && !in_acc, a_vld_r && $stable(a_item_r), "input stage changed while stalled")
  `M68KEA_ASSERT_IMP(a_accept_frees, in_acc && a_vld_r, b_move, "input taken over a held word")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for m68k_effective_address_unit_top: a directed table, then random accesses
// under four sender/receiver idle mixes, each result word checked against a predictor or pinned result.
// Depends on m68kea_pkg and the top-level RTL only.
module tb;
  import m68kea_pkg::*;

  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam logic [2:0] EXT_RSVD5 = 3'd5;
  localparam logic [2:0] EXT_RSVD7 = 3'd7;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    action_t     action;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0]  access_size;
    logic [1:0]  ext_words;
  } ea_result_t;

  typedef struct {
    item_t      it;
    bit         pinned;
    ea_result_t res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Predictor copy of the register file
  logic [31:0] dreg [8];
  logic [31:0] areg [8];

  ea_result_t pending_results[$];
  stim_row_t  dir_rows[$];
  bit         pin_now;
  ea_result_t pin_result;
  int         idle_pct;
  int         stall_pct;
  int         fails;
  int         words_checked;
  int         action_seen [5];
  int         cycle_count;

  m68k_effective_address_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic ea_result_t outcome(input action_t a, input logic [31:0] addr,
                                         input logic [31:0] d, input logic [1:0] asz,
                                         input logic [1:0] ew);
    ea_result_t r;
    r.action      = a;
    r.address     = addr;
    r.data        = d;
    r.access_size = asz;
    r.ext_words   = ew;
    return r;
  endfunction

  // Base plus signed 8-bit displacement plus index register from a brief extension word
  function automatic logic [31:0] index_ea(input logic [31:0] base, input logic [15:0] ew);
    logic [31:0] xr;
    xr = ew[15] ? areg[ew[14:12]] : dreg[ew[14:12]];
    if (!ew[11]) xr = {{16{xr[15]}}, xr[15:0]};
    return base + {{24{ew[7]}}, ew[7:0]} + xr;
  endfunction

  function automatic ea_result_t predict_access(input item_t it);
    ea_result_t  r;
    logic [31:0] mask;
    logic [31:0] stepv;
    logic [31:0] disp16;
    logic [2:0]  n;
    bit          mem;
    r = '0;
    r.action = ACT_INVALID;
    n = it.reg_req;
    mem = 1'b0;
    disp16 = {{16{it.ext_first[15]}}, it.ext_first};
    case (it.size_code)
      SZ_BYTE: begin
        mask = 32'h0000_00FF;
        stepv = (n == SP_IDX) ? 32'd2 : 32'd1;
      end
      SZ_WORD: begin
        mask = 32'h0000_FFFF;
        stepv = 32'd2;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        stepv = 32'd4;
      end
    endcase
    if (it.kind == KIND_LOAD) begin
      if (it.mode == MODE_DREG || it.mode == MODE_AREG) begin
        if (it.mode == MODE_DREG) dreg[n] = it.value;
        else areg[n] = it.value;
        r.action = ACT_REG;
        r.data = it.value;
        r.access_size = SZ_LONG;
      end
    end else if ((it.kind == KIND_FETCH || it.kind == KIND_STORE) &&
                 it.size_code != SZ_NONE) begin
      mem = 1'b1;
      case (it.mode)
        MODE_IND: r.address = areg[n];
        MODE_POSTINC: begin
          r.address = areg[n];
          areg[n] = areg[n] + stepv;
        end
        MODE_PREDEC: begin
          areg[n] = areg[n] - stepv;
          r.address = areg[n];
        end
        MODE_DISP: begin
          r.address = areg[n] + disp16;
          r.ext_words = 2'd1;
        end
        MODE_INDEX: begin
          r.address = index_ea(areg[n], it.ext_first);
          r.ext_words = 2'd1;
        end
        MODE_EXT: begin
          case (n)
            EXT_ABS_W: begin
              r.address = disp16;
              r.ext_words = 2'd1;
            end
            EXT_ABS_L: begin
              r.address = {it.ext_first, it.ext_second};
              r.ext_words = 2'd2;
            end
            EXT_PC_DISP: begin
              r.address = it.ext_pc + disp16;
              r.ext_words = 2'd1;
            end
            EXT_PC_INDEX: begin
              r.address = index_ea(it.ext_pc, it.ext_first);
              r.ext_words = 2'd1;
            end
            default: mem = 1'b0;
          endcase
        end
        default: mem = 1'b0;
      endcase
      if (mem) begin
        r.access_size = it.size_code;
        if (it.kind == KIND_FETCH) begin
          r.action = ACT_READ;
        end else begin
          r.action = ACT_WRITE;
          r.data = it.value & mask;
        end
      end else if (it.kind == KIND_FETCH) begin
        if (it.mode == MODE_DREG || it.mode == MODE_AREG) begin
          r.action = ACT_VALUE;
          r.data = (it.mode == MODE_DREG) ? dreg[n] : areg[n];
          r.access_size = it.size_code;
        end else if (it.mode == MODE_EXT && n == EXT_IMM) begin
          r.action = ACT_VALUE;
          r.access_size = it.size_code;
          if (it.size_code == SZ_LONG) begin
            r.data = {it.ext_first, it.ext_second};
            r.ext_words = 2'd2;
          end else begin
            r.data = {16'h0000, it.ext_first} & mask;
            r.ext_words = 2'd1;
          end
        end
      end else begin
        if (it.mode == MODE_DREG) begin
          // byte and word stores keep the upper register bits
          dreg[n] = (dreg[n] & ~mask) | (it.value & mask);
          r.action = ACT_REG;
          r.data = dreg[n];
          r.access_size = it.size_code;
        end else if (it.mode == MODE_AREG) begin
          areg[n] = (it.size_code == SZ_WORD) ? {{16{it.value[15]}}, it.value[15:0]}
                                              : it.value;
          r.action = ACT_REG;
          r.data = areg[n];
          r.access_size = it.size_code;
        end
      end
    end
    if (r.action == ACT_INVALID) begin
      r = '0;
      r.action = ACT_INVALID;
    end
    return r;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    it.kind = (pick < 40) ? KIND_FETCH : (pick < 75) ? KIND_STORE :
              (pick < 95) ? KIND_LOAD : KIND_RSVD;
    it.mode = 3'($urandom_range(7));
    it.reg_req = 3'($urandom_range(7));
    if (it.kind == KIND_LOAD && $urandom_range(99) < 85) it.mode = 3'($urandom_range(1));
    // favor the valid sub-modes of mode seven
    if (it.mode == MODE_EXT && $urandom_range(99) < 85) begin
      it.reg_req = 3'($urandom_range(EXT_IMM));
    end
    it.size_code = ($urandom_range(99) < 5) ? SZ_NONE : 2'($urandom_range(SZ_LONG));
    it.ext_first = 16'($urandom);
    it.ext_second = 16'($urandom);
    it.ext_pc = $urandom;
    case ($urandom_range(9))
      0: it.value = 32'h0000_0000;
      1: it.value = 32'hFFFF_FFFF;
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [2:0] mode, input logic [2:0] rg,
                         input logic [1:0] sz, input logic [15:0] e1, input logic [15:0] e2,
                         input logic [31:0] pc, input logic [31:0] val, input bit pinned,
                         input ea_result_t res);
    stim_row_t row;
    row.it = '{kind, mode, rg, sz, e1, e2, pc, val};
    row.pinned = pinned;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input item_t it, input bit pinned, input ea_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.value, it.ext_pc, it.ext_second, it.ext_first, it.size_code,
                 it.reg_req, it.mode};
    in_tuser <= it.kind;
    pin_now <= pinned;
    pin_result <= res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    ea_result_t got;
    ea_result_t want;
    item_t      acc;
    if (rst_n) begin
      // compare the outgoing word before queuing the incoming one
      if (out_tvalid && out_tready) begin
        got.action      = action_t'(out_tuser);
        got.address     = out_tdata[31:0];
        got.data        = out_tdata[63:32];
        got.access_size = out_tdata[65:64];
        got.ext_words   = out_tdata[67:66];
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: action %0d address %h data %h",
                 got.action, got.address, got.data);
          fails++;
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          action_seen[want.action]++;
          if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            fails++;
          end
          if (got.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, got.address);
            fails++;
          end
          if (got.data !== want.data) begin
            $error("data: expected %h, got %h", want.data, got.data);
            fails++;
          end
          if (got.access_size !== want.access_size) begin
            $error("access_size: expected %0d, got %0d", want.access_size, got.access_size);
            fails++;
          end
          if (got.ext_words !== want.ext_words) begin
            $error("ext_words: expected %0d, got %0d", want.ext_words, got.ext_words);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        acc.kind       = in_tuser;
        acc.mode       = in_tdata[2:0];
        acc.reg_req    = in_tdata[5:3];
        acc.size_code  = in_tdata[7:6];
        acc.ext_first  = in_tdata[23:8];
        acc.ext_second = in_tdata[39:24];
        acc.ext_pc     = in_tdata[71:40];
        acc.value      = in_tdata[103:72];
        want = predict_access(acc);
        if (pin_now) want = pin_result;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** m68k_effective_address_unit_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    idle_mix = '{0, 74, 0, 37};
    stall_mix = '{0, 0, 74, 37};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    pin_now = 1'b0;
    pin_result = '0;
    idle_pct = 0;
    stall_pct = 0;
    fails = 0;
    words_checked = 0;
    cycle_count = 0;
    foreach (action_seen[i]) action_seen[i] = 0;
    for (int i = 0; i < 8; i++) begin
      dreg[i] = '0;
      areg[i] = '0;
    end

    // registers read zero after reset
    add_row(KIND_FETCH, MODE_DREG, 3'd0, SZ_LONG, 16'h0000, 16'h0000, 32'h0, 32'h0,
            1'b1, outcome(ACT_VALUE, 32'h0, 32'h0, SZ_LONG, 2'd0));
    // loads ignore the size code
    add_row(KIND_LOAD, MODE_DREG, 3'd3, SZ_NONE, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF,
            1'b1, outcome(ACT_REG, 32'h0, 32'hFFFF_FFFF, SZ_LONG, 2'd0));
    add_row(KIND_LOAD, MODE_AREG, SP_IDX, SZ_BYTE, 16'h0000, 16'h0000, 32'h0, 32'h0000_1000,
            1'b1, outcome(ACT_REG, 32'h0, 32'h0000_1000, SZ_LONG, 2'd0));
    add_row(KIND_LOAD, MODE_AREG, 3'd2, SZ_LONG, 16'h0000, 16'h0000, 32'h0, 32'h8000_0000,
            1'b1, outcome(ACT_REG, 32'h0, 32'h8000_0000, SZ_LONG, 2'd0));
    add_row(KIND_LOAD, MODE_DREG, 3'd5, SZ_WORD, 16'h0000, 16'h0000, 32'h0, 32'h0000_8004,
            1'b1, outcome(ACT_REG, 32'h0, 32'h0000_8004, SZ_LONG, 2'd0));
    // invalid requests
    add_row(KIND_LOAD, MODE_IND, 3'd1, SZ_LONG, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    add_row(KIND_RSVD, MODE_DREG, 3'd3, SZ_LONG, 16'h0000, 16'h0000, 32'h0, 32'h0,
            1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    add_row(KIND_FETCH, MODE_DREG, 3'd3, SZ_NONE, 16'h0000, 16'h0000, 32'h0, 32'h0,
            1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    add_row(KIND_STORE, MODE_EXT, EXT_IMM, SZ_LONG, 16'h1234, 16'h5678, 32'h0, 32'h1,
            1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    add_row(KIND_FETCH, MODE_EXT, EXT_RSVD5, SZ_WORD, 16'h1234, 16'h5678, 32'h0, 32'h0,
            1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    add_row(KIND_STORE, MODE_EXT, EXT_RSVD7, SZ_WORD, 16'h1234, 16'h5678, 32'h0, 32'h1,
            1'b1, outcome(ACT_INVALID, 32'h0, 32'h0, SZ_BYTE, 2'd0));
    // immediates and absolute addresses
    add_row(KIND_FETCH, MODE_EXT, EXT_IMM, SZ_BYTE, 16'hABCD, 16'h1234, 32'h0, 32'h0,
            1'b1, outcome(ACT_VALUE, 32'h0, 32'h0000_00CD, SZ_BYTE, 2'd1));
    add_row(KIND_FETCH, MODE_EXT, EXT_IMM, SZ_LONG, 16'hABCD, 16'h1234, 32'h0, 32'h0,
            1'b1, outcome(ACT_VALUE, 32'h0, 32'hABCD_1234, SZ_LONG, 2'd2));
    add_row(KIND_FETCH, MODE_EXT, EXT_ABS_W, SZ_WORD, 16'h8000, 16'h0000, 32'h0, 32'h0,
            1'b1, outcome(ACT_READ, 32'hFFFF_8000, 32'h0, SZ_WORD, 2'd1));
    add_row(KIND_STORE, MODE_EXT, EXT_ABS_L, SZ_BYTE, 16'hFFFF, 16'hFFFF, 32'h0, 32'h1234_5678,
            1'b1, outcome(ACT_WRITE, 32'hFFFF_FFFF, 32'h0000_0078, SZ_BYTE, 2'd2));
    // stack pointer byte steps, wrap, displacement and index forms
    add_row(KIND_FETCH, MODE_POSTINC, SP_IDX, SZ_BYTE, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_FETCH, MODE_PREDEC, SP_IDX, SZ_BYTE, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_STORE, MODE_PREDEC, 3'd2, SZ_LONG, 16'h0, 16'h0, 32'h0, 32'hDEAD_BEEF,
            1'b0, '0);
    add_row(KIND_FETCH, MODE_AREG, 3'd2, SZ_WORD, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_FETCH, MODE_DISP, 3'd2, SZ_WORD, 16'h7FFF, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_FETCH, MODE_INDEX, SP_IDX, SZ_LONG, 16'h5080, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_FETCH, MODE_EXT, EXT_PC_INDEX, SZ_BYTE, 16'hA87F, 16'h0, 32'hFFFF_FFFF,
            32'h0, 1'b0, '0);
    // register stores: partial data writes and address word sign extension
    add_row(KIND_STORE, MODE_DREG, 3'd3, SZ_BYTE, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(KIND_STORE, MODE_AREG, 3'd4, SZ_WORD, 16'h0, 16'h0, 32'h0, 32'h0000_8000,
            1'b0, '0);
    add_row(KIND_STORE, MODE_DREG, 3'd3, SZ_WORD, 16'h0, 16'h0, 32'h0, 32'hFFFF_0000,
            1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      repeat (RANDOM_PER_PHASE) send_word(rand_item(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d directed and %0d random words over four idle/stall mixes; %0d checked.",
             dir_rows.size(), 4 * RANDOM_PER_PHASE, words_checked);
    $display("Results by action: value %0d, read %0d, write %0d, register %0d, invalid %0d.",
             action_seen[ACT_VALUE], action_seen[ACT_READ], action_seen[ACT_WRITE],
             action_seen[ACT_REG], action_seen[ACT_INVALID]);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("** m68k_effective_address_unit_top: PASSED **");
    end else begin
      $display("** m68k_effective_address_unit_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/m68kea_pkg.sv
rtl/m68kea_ram.sv
rtl/m68kea_regs.sv
rtl/m68k_effective_address_unit_top.sv
verif/tb.sv
